// ===== design/brbpf_pkg.sv =====
// Shared types and constants for the byte ring buffer packet framer.
// Used by brbpf_ctrl and by the top level; depends on nothing else.
`default_nettype none

package brbpf_pkg;

   // Default geometry
   localparam int DEPTH_DEFAULT        = 4096;
   localparam int HEADER_BYTES_DEFAULT = 4;

   // Field widths
   localparam int BYTE_W = 8;
   localparam int RUN_W  = 13;
   localparam int USED_W = 13;
   localparam int HLEN_W = 16;
   // Wide enough for a full fill level and for header bytes plus a 16-bit length
   localparam int FRAME_CMP_W = 18;

   // Stream packing
   localparam int REQ_TDATA_W = 24;
   localparam int RSP_TDATA_W = 48;

   // Request kinds
   localparam logic REQ_PUSH = 1'b0;
   localparam logic REQ_POP  = 1'b1;

   // One result item
   typedef struct packed {
      logic                  packet_complete;
      logic [HLEN_W-1:0]     header_length;
      logic                  is_full;
      logic                  ring_empty;
      logic [USED_W-1:0]     used_bytes;
      logic [BYTE_W-1:0]     pop_byte;
      logic                  accepted;
   } result_type;

endpackage

`default_nettype wire

// ===== design/brbpf_ram.sv =====
// Generic simple dual-port RAM: one write port, one registered read port.
// Stand-alone; no package dependency.
`default_nettype none

module brbpf_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096,
   localparam int ADDR_W = $clog2(DEPTH)
) (
   input  wire logic              clock,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]  wr_data,
   input  wire logic              rd_en,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic      [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   // Write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
   end

   // Registered read, held while not enabled
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data <= mem[rd_addr];
      end
   end

endmodule

`default_nettype wire

// ===== design/brbpf_ctrl.sv =====
// Ring pointers, fill count and the read sequencer around the byte memory.
// Depends on brbpf_pkg; drives the ports of one brbpf_ram instance.
`default_nettype none

module brbpf_ctrl #(
   parameter int DEPTH        = brbpf_pkg::DEPTH_DEFAULT,
   parameter int HEADER_BYTES = brbpf_pkg::HEADER_BYTES_DEFAULT,
   localparam int IDX_W = $clog2(DEPTH)
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   // request side
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic                          req_kind,
   input  wire logic [brbpf_pkg::BYTE_W-1:0]  req_byte,
   input  wire logic [brbpf_pkg::RUN_W-1:0]   req_run,
   // memory side
   output logic                               ram_we,
   output logic [IDX_W-1:0]                   ram_waddr,
   output logic [brbpf_pkg::BYTE_W-1:0]       ram_wdata,
   output logic                               ram_re,
   output logic [IDX_W-1:0]                   ram_raddr,
   input  wire logic [brbpf_pkg::BYTE_W-1:0]  ram_rdata,
   // result side
   output logic                               res_valid,
   input  wire logic                          res_ready,
   output brbpf_pkg::result_type              res
);

   localparam int CNT_W = $clog2(DEPTH + 1);
   localparam int CMP_W = (CNT_W > brbpf_pkg::RUN_W) ? CNT_W : brbpf_pkg::RUN_W;
   localparam int FC_W  = brbpf_pkg::FRAME_CMP_W;
   localparam logic [IDX_W:0]  DEPTH_X = (IDX_W + 1)'(DEPTH);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(DEPTH);

   typedef enum logic [3:0] {
      ST_IDLE = 4'b0001,
      ST_HI   = 4'b0010,
      ST_LO   = 4'b0100,
      ST_FIN  = 4'b1000
   } state_type;

   state_type                     state_ff, state_in;
   logic [IDX_W-1:0]              rd_idx_ff, rd_idx_in;
   logic [IDX_W-1:0]              wr_idx_ff, wr_idx_in;
   logic [CNT_W-1:0]              free_ff, free_in;
   logic                          acc_ff, acc_in;
   logic                          popped_ff, popped_in;
   logic [brbpf_pkg::BYTE_W-1:0]  pop_byte_ff, pop_byte_in;
   logic [brbpf_pkg::BYTE_W-1:0]  hi_ff, hi_in;

   logic                          take;
   logic [brbpf_pkg::RUN_W-1:0]   run_eff;
   logic [CNT_W-1:0]              used;
   logic [CMP_W-1:0]              used_ext;
   logic                          push_ok, pop_ok, do_push, do_pop;
   logic [IDX_W:0]                sum1w, sum1r, sum2, sum3;
   logic [IDX_W-1:0]              wr_next, rd_next, front2, front3;
   logic                          has_hdr;
   logic [brbpf_pkg::HLEN_W-1:0]  hdr_len;

   // Admission: a run of zero counts as one
   assign take     = req_valid && (state_ff == ST_IDLE);
   assign run_eff  = (req_run == '0) ? brbpf_pkg::RUN_W'(1) : req_run;
   assign used     = DEPTH_C - free_ff;
   assign used_ext = CMP_W'(used);
   assign push_ok  = CMP_W'(free_ff) >= CMP_W'(run_eff);
   assign pop_ok   = used_ext >= CMP_W'(run_eff);
   assign do_push  = take && (req_kind == brbpf_pkg::REQ_PUSH) && push_ok;
   assign do_pop   = take && (req_kind == brbpf_pkg::REQ_POP) && pop_ok;

   // Ring arithmetic with wrap at DEPTH
   always_comb begin
      sum1w   = {1'b0, wr_idx_ff} + (IDX_W + 1)'(1);
      sum1r   = {1'b0, rd_idx_ff} + (IDX_W + 1)'(1);
      sum2    = {1'b0, rd_idx_ff} + (IDX_W + 1)'(2);
      sum3    = {1'b0, rd_idx_ff} + (IDX_W + 1)'(3);
      if (sum1w >= DEPTH_X) sum1w = sum1w - DEPTH_X;
      if (sum1r >= DEPTH_X) sum1r = sum1r - DEPTH_X;
      if (sum2 >= DEPTH_X)  sum2  = sum2 - DEPTH_X;
      if (sum3 >= DEPTH_X)  sum3  = sum3 - DEPTH_X;
      wr_next = sum1w[IDX_W-1:0];
      rd_next = sum1r[IDX_W-1:0];
      front2  = sum2[IDX_W-1:0];
      front3  = sum3[IDX_W-1:0];
   end

   // Memory ports: write on push, read the popped byte then the two length bytes
   assign ram_we    = do_push;
   assign ram_waddr = wr_idx_ff;
   assign ram_wdata = req_byte;
   always_comb begin
      ram_re    = 1'b0;
      ram_raddr = rd_idx_ff;
      unique case (state_ff)
         ST_IDLE: begin
            ram_re    = do_pop;
            ram_raddr = rd_idx_ff;
         end
         ST_HI: begin
            ram_re    = 1'b1;
            ram_raddr = front2;
         end
         ST_LO: begin
            ram_re    = 1'b1;
            ram_raddr = front3;
         end
         ST_FIN: begin
            ram_re    = 1'b0;
            ram_raddr = front3;
         end
         default: begin
            ram_re    = 1'b0;
            ram_raddr = rd_idx_ff;
         end
      endcase
   end

   // Sequencer and pointer updates
   always_comb begin
      state_in    = state_ff;
      rd_idx_in   = rd_idx_ff;
      wr_idx_in   = wr_idx_ff;
      free_in     = free_ff;
      acc_in      = acc_ff;
      popped_in   = popped_ff;
      pop_byte_in = pop_byte_ff;
      hi_in       = hi_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (take) begin
               acc_in    = do_push || do_pop;
               popped_in = do_pop;
               state_in  = ST_HI;
            end
            if (do_push) begin
               wr_idx_in = wr_next;
               free_in   = free_ff - CNT_W'(1);
            end
            if (do_pop) begin
               rd_idx_in = rd_next;
               free_in   = free_ff + CNT_W'(1);
            end
         end
         ST_HI: begin
            pop_byte_in = popped_ff ? ram_rdata : '0;
            state_in    = ST_LO;
         end
         ST_LO: begin
            hi_in    = ram_rdata;
            state_in = ST_FIN;
         end
         ST_FIN: begin
            if (res_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         rd_idx_ff <= '0;
         wr_idx_ff <= '0;
         free_ff   <= DEPTH_C;
         acc_ff    <= 1'b0;
         popped_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         rd_idx_ff <= rd_idx_in;
         wr_idx_ff <= wr_idx_in;
         free_ff   <= free_in;
         acc_ff    <= acc_in;
         popped_ff <= popped_in;
      end
   end

   always_ff @(posedge clock) begin
      pop_byte_ff <= pop_byte_in;
      hi_ff       <= hi_in;
   end

   // Framing view of the front; length bytes arrive in ST_FIN as hi_ff and ram_rdata
   assign has_hdr = used_ext >= CMP_W'(4);
   assign hdr_len = has_hdr ? {hi_ff, ram_rdata} : '0;

   assign req_ready = (state_ff == ST_IDLE);
   assign res_valid = (state_ff == ST_FIN);

   always_comb begin
      res.accepted        = acc_ff;
      res.pop_byte        = pop_byte_ff;
      res.used_bytes      = used_ext[brbpf_pkg::USED_W-1:0];
      res.ring_empty      = (free_ff == DEPTH_C);
      res.is_full         = (free_ff == '0);
      res.header_length   = hdr_len;
      res.packet_complete = has_hdr &&
         (FC_W'(used) >= FC_W'(HEADER_BYTES) + FC_W'(hdr_len));
   end

   // Free count never exceeds the ring size
   a_free_bound: assert property (@(posedge clock) disable iff (reset)
      free_ff <= DEPTH_C)
      else $error("free count above depth");

   // Pointers stay inside the ring
   a_idx_bound: assert property (@(posedge clock) disable iff (reset)
      (IDX_W + 1)'(rd_idx_ff) < DEPTH_X && (IDX_W + 1)'(wr_idx_ff) < DEPTH_X)
      else $error("ring pointer out of range");

   // Empty or full ring means the pointers meet
   a_ptr_meet: assert property (@(posedge clock) disable iff (reset)
      (free_ff == '0 || free_ff == DEPTH_C) |-> wr_idx_ff == rd_idx_ff)
      else $error("pointers disagree with fill count");

   // An accepted push takes exactly one free entry
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      do_push |=> free_ff == $past(free_ff) - CNT_W'(1))
      else $error("push did not consume one entry");

   // No item is taken while a result is in flight
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      take |=> !req_ready ##1 !req_ready ##1 !req_ready)
      else $error("request taken mid-sequence");

endmodule

`default_nettype wire

// ===== design/byte_ring_buffer_packet_framer_core.sv =====
// Byte ring buffer with length-prefix framing view at its front.
//
// Channels: the request stream (req_t*) carries one push or pop per request,
// with the count of bytes left in its run; a run is refused unless the whole
// run fits (push) or is stored (pop). The result stream (rsp_t*) returns one
// result per request: accepted flag, popped byte, fill level, empty and full
// flags, the big-endian length at front offsets 2 and 3, and packet complete.
//
// Timing: a request is taken, then the sequencer reads the popped byte and
// the two length bytes from the single-read-port byte memory one per cycle.
// The result is registered after those reads; a new request is taken only
// once the previous result has been handed off to the output register.
//
// Reset (synchronous, active high) empties the ring: both pointers go to 0
// and the free count to DEPTH. Memory contents are not cleared.
// When the receiver stalls, the result waits in the output register; the
// next request is still taken and worked on, and stops at its final step
// until the output register frees up.
// Depends on brbpf_pkg, brbpf_ram and brbpf_ctrl.
`default_nettype none

module byte_ring_buffer_packet_framer_core #(
   parameter int DEPTH        = brbpf_pkg::DEPTH_DEFAULT,
   parameter int HEADER_BYTES = brbpf_pkg::HEADER_BYTES_DEFAULT
) (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   // [0] req_type, [8:1] data_byte, [21:9] run_left, [23:22] zero
   input  wire logic [brbpf_pkg::REQ_TDATA_W-1:0]   req_tdata,
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   // [0] accepted, [8:1] pop_byte, [21:9] used_bytes, [22] ring_empty,
   // [23] is_full, [39:24] header_length, [40] packet_complete, [47:41] zero
   output logic [brbpf_pkg::RSP_TDATA_W-1:0]        rsp_tdata
);

   localparam int IDX_W = $clog2(DEPTH);
   localparam int RES_W = $bits(brbpf_pkg::result_type);

   logic                          ram_we, ram_re;
   logic [IDX_W-1:0]              ram_waddr, ram_raddr;
   logic [brbpf_pkg::BYTE_W-1:0]  ram_wdata, ram_rdata;
   logic                          res_valid, res_ready;
   brbpf_pkg::result_type         res;
   logic                          rsp_valid_ff, rsp_valid_in;
   logic [RES_W-1:0]              rsp_data_ff, rsp_data_in;

   brbpf_ram #(
      .WIDTH (brbpf_pkg::BYTE_W),
      .DEPTH (DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (ram_waddr),
      .wr_data (ram_wdata),
      .rd_en   (ram_re),
      .rd_addr (ram_raddr),
      .rd_data (ram_rdata)
   );

   brbpf_ctrl #(
      .DEPTH        (DEPTH),
      .HEADER_BYTES (HEADER_BYTES)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_tvalid),
      .req_ready (req_tready),
      .req_kind  (req_tdata[0]),
      .req_byte  (req_tdata[8:1]),
      .req_run   (req_tdata[21:9]),
      .ram_we    (ram_we),
      .ram_waddr (ram_waddr),
      .ram_wdata (ram_wdata),
      .ram_re    (ram_re),
      .ram_raddr (ram_raddr),
      .ram_rdata (ram_rdata),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // Output register: load when empty or being drained
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_valid_ff && rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
      if (res_valid && res_ready) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = res;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = brbpf_pkg::RSP_TDATA_W'(rsp_data_ff);

endmodule

`default_nettype wire
